// ----- rtl/ipv4_lpm_pkg.sv -----
// Shared constants and types for the IPv4 longest-prefix-match route lookup.
`timescale 1ns / 1ps
`default_nettype none
package ipv4_lpm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ACTIVE_W    = 9;
  localparam int ADDR_W      = 32;
  localparam int IFACE_W     = 4;
  localparam int SLOT_W      = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int REG_ACTIVE_ENTRIES = 0;

  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/ipv4_lpm_table.sv -----
// Route table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_lpm_table (
  input  wire logic                  clk,
  input  wire ipv4_lpm_pkg::tbl_req_t req,
  input  wire ipv4_lpm_pkg::entry_t   wdata,
  output      ipv4_lpm_pkg::entry_t   rdata
);

  ipv4_lpm_pkg::entry_t mem [ipv4_lpm_pkg::TABLE_DEPTH];
  ipv4_lpm_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/ipv4_lpm_ctrl.sv -----
// Command sequencer: table writes, lookup scan and best-match tracking.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_lpm_ctrl (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic                                  in_op,
  input  wire logic [ipv4_lpm_pkg::SLOT_W-1:0]       in_entry_index,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_entry_prefix,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_entry_mask,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_entry_hop_addr,
  input  wire logic [ipv4_lpm_pkg::IFACE_W-1:0]      in_entry_interface,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_dest_addr,
  input  wire logic [ipv4_lpm_pkg::ACTIVE_W-1:0]     active_entries,
  output      ipv4_lpm_pkg::tbl_req_t                tbl_req,
  output      ipv4_lpm_pkg::entry_t                  tbl_wdata,
  input  wire ipv4_lpm_pkg::entry_t                  tbl_rdata,
  output      logic                                  out_valid,
  output      logic                                  out_found,
  output      logic [ipv4_lpm_pkg::ADDR_W-1:0]       out_hop_addr,
  output      logic [ipv4_lpm_pkg::IFACE_W-1:0]      out_out_interface,
  output      logic [ipv4_lpm_pkg::SLOT_W-1:0]       out_match_index
);

  ipv4_lpm_pkg::state_t state_r, state_nxt;

  logic [ipv4_lpm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ipv4_lpm_pkg::CNT_W-1:0]   limit_r, limit_nxt;
  logic [ipv4_lpm_pkg::ADDR_W-1:0]  dest_r, dest_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [ipv4_lpm_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                             hit_r, hit_nxt;
  logic [ipv4_lpm_pkg::ADDR_W-1:0]  best_mask_r, best_mask_nxt;
  logic [ipv4_lpm_pkg::ADDR_W-1:0]  best_hop_r, best_hop_nxt;
  logic [ipv4_lpm_pkg::IFACE_W-1:0] best_port_r, best_port_nxt;
  logic [ipv4_lpm_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;

  logic                             accept;
  logic                             lookup_go;
  logic                             slot_ok;
  logic                             match;
  logic                             better;
  logic [ipv4_lpm_pkg::CNT_W-1:0]   cnt_inc;
  logic [ipv4_lpm_pkg::CNT_W-1:0]   limit_in;

  assign accept    = start && (state_r == ipv4_lpm_pkg::ST_IDLE);
  assign lookup_go = accept && (in_op == ipv4_lpm_pkg::OP_LOOKUP);
  assign slot_ok   = 32'(in_entry_index) < ipv4_lpm_pkg::TABLE_DEPTH;
  assign cnt_inc   = ipv4_lpm_pkg::CNT_W'(cnt_r + 1'b1);
  assign limit_in  = (32'(active_entries) > ipv4_lpm_pkg::TABLE_DEPTH)
                     ? ipv4_lpm_pkg::CNT_W'(ipv4_lpm_pkg::TABLE_DEPTH)
                     : ipv4_lpm_pkg::CNT_W'(active_entries);

  assign match  = (dest_r & tbl_rdata.mask) == tbl_rdata.prefix;
  assign better = rd_vld_r && match && (!hit_r || (tbl_rdata.mask >= best_mask_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipv4_lpm_pkg::ST_IDLE: begin
        if (lookup_go) begin
          state_nxt = (limit_in == '0) ? ipv4_lpm_pkg::ST_DONE : ipv4_lpm_pkg::ST_SCAN;
        end
      end
      ipv4_lpm_pkg::ST_SCAN: begin
        if (cnt_inc == limit_r) begin
          state_nxt = ipv4_lpm_pkg::ST_DRAIN;
        end
      end
      ipv4_lpm_pkg::ST_DRAIN: state_nxt = ipv4_lpm_pkg::ST_DONE;
      ipv4_lpm_pkg::ST_DONE:  state_nxt = ipv4_lpm_pkg::ST_IDLE;
      default:                state_nxt = ipv4_lpm_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    dest_nxt      = dest_r;
    rd_vld_nxt    = (state_r == ipv4_lpm_pkg::ST_SCAN);
    rd_idx_nxt    = cnt_r[ipv4_lpm_pkg::IDX_W-1:0];
    hit_nxt       = hit_r;
    best_mask_nxt = best_mask_r;
    best_hop_nxt  = best_hop_r;
    best_port_nxt = best_port_r;
    best_idx_nxt  = best_idx_r;
    if (lookup_go) begin
      cnt_nxt   = '0;
      limit_nxt = limit_in;
      dest_nxt  = in_dest_addr;
      hit_nxt   = 1'b0;
    end else if (state_r == ipv4_lpm_pkg::ST_SCAN) begin
      cnt_nxt = cnt_inc;
    end
    if (better) begin
      hit_nxt       = 1'b1;
      best_mask_nxt = tbl_rdata.mask;
      best_hop_nxt  = tbl_rdata.hop;
      best_port_nxt = tbl_rdata.port;
      best_idx_nxt  = rd_idx_r;
    end
  end

  // outputs
  always_comb begin
    busy              = (state_r != ipv4_lpm_pkg::ST_IDLE);
    out_valid         = (state_r == ipv4_lpm_pkg::ST_DONE);
    out_found         = hit_r;
    out_hop_addr      = hit_r ? best_hop_r : '0;
    out_out_interface = hit_r ? best_port_r : '0;
    out_match_index   = hit_r ? ipv4_lpm_pkg::SLOT_W'(best_idx_r) : '0;

    tbl_req.we        = accept && (in_op == ipv4_lpm_pkg::OP_WRITE) && slot_ok;
    tbl_req.waddr     = ipv4_lpm_pkg::IDX_W'(in_entry_index);
    tbl_req.re        = (state_r == ipv4_lpm_pkg::ST_SCAN);
    tbl_req.raddr     = cnt_r[ipv4_lpm_pkg::IDX_W-1:0];

    tbl_wdata.prefix  = in_entry_prefix;
    tbl_wdata.mask    = in_entry_mask;
    tbl_wdata.hop     = in_entry_hop_addr;
    tbl_wdata.port    = in_entry_interface;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ipv4_lpm_pkg::ST_IDLE;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      cnt_r    <= '0;
      limit_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      hit_r    <= hit_nxt;
      cnt_r    <= cnt_nxt;
      limit_r  <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dest_r      <= dest_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_mask_r <= best_mask_nxt;
    best_hop_r  <= best_hop_nxt;
    best_port_r <= best_port_nxt;
    best_idx_r  <= best_idx_nxt;
  end

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == ipv4_lpm_pkg::OP_LOOKUP)) |=> busy)
    else $error("accepted lookup did not raise busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ipv4_lpm_pkg::ST_SCAN) |-> (cnt_r < limit_r))
    else $error("scan address beyond active count");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.we |-> !tbl_req.re)
    else $error("table write during lookup scan");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ipv4_lpm_pkg::ST_SCAN))
    else $error("read beat without a scan read");
`endif

endmodule
`default_nettype wire

// ----- rtl/ipv4_longest_prefix_match_top.sv -----
// Top level: APB register, command sequencer and route table memory.
// Lookup over N = min(active_entries, 256) slots, one slot read a cycle: scan, drain,
// then done strobes the result (N of 0 goes straight to done); start is ignored while busy.
// A route write is done on accept, gives no result and leaves busy low.
// Results hold for one cycle on out_valid; the receiver cannot stall.
// rst_n is synchronous: it clears control state and active_entries, not the table.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_longest_prefix_match_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic                                  in_op,
  input  wire logic [ipv4_lpm_pkg::SLOT_W-1:0]       in_entry_index,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_entry_prefix,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_entry_mask,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_entry_hop_addr,
  input  wire logic [ipv4_lpm_pkg::IFACE_W-1:0]      in_entry_interface,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0]       in_dest_addr,
  output      logic                                  out_valid,
  output      logic                                  out_found,
  output      logic [ipv4_lpm_pkg::ADDR_W-1:0]       out_hop_addr,
  output      logic [ipv4_lpm_pkg::IFACE_W-1:0]      out_out_interface,
  output      logic [ipv4_lpm_pkg::SLOT_W-1:0]       out_match_index,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [ipv4_lpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [ipv4_lpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output      logic [ipv4_lpm_pkg::CFG_DATA_W-1:0]   prdata,
  output      logic                                  pready
);

  logic [ipv4_lpm_pkg::ACTIVE_W-1:0] cfg_active_r, cfg_active_nxt;
  logic                              cfg_wr;
  logic                              cfg_sel_active;
  ipv4_lpm_pkg::tbl_req_t            tbl_req;
  ipv4_lpm_pkg::entry_t              tbl_wdata;
  ipv4_lpm_pkg::entry_t              tbl_rdata;

  assign pready         = 1'b1;
  assign cfg_wr         = psel && penable && pwrite && pready;
  assign cfg_sel_active = (paddr ==
                           ipv4_lpm_pkg::CFG_ADDR_W'(4 * ipv4_lpm_pkg::REG_ACTIVE_ENTRIES));

  always_comb begin
    cfg_active_nxt = cfg_active_r;
    if (cfg_wr && cfg_sel_active) begin
      cfg_active_nxt = pwdata[ipv4_lpm_pkg::ACTIVE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_sel_active) begin
      prdata = ipv4_lpm_pkg::CFG_DATA_W'(cfg_active_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= '0;
    end else begin
      cfg_active_r <= cfg_active_nxt;
    end
  end

  ipv4_lpm_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_entry_index     (in_entry_index),
    .in_entry_prefix    (in_entry_prefix),
    .in_entry_mask      (in_entry_mask),
    .in_entry_hop_addr  (in_entry_hop_addr),
    .in_entry_interface (in_entry_interface),
    .in_dest_addr       (in_dest_addr),
    .active_entries     (cfg_active_r),
    .tbl_req            (tbl_req),
    .tbl_wdata          (tbl_wdata),
    .tbl_rdata          (tbl_rdata),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_hop_addr       (out_hop_addr),
    .out_out_interface  (out_out_interface),
    .out_match_index    (out_match_index)
  );

  ipv4_lpm_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

endmodule
`default_nettype wire
